FILE: src/fqsq_pkg.sv
// shared types, constants and slot helpers for the fifo queue with scan queries
package fqsq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int ACTION_W    = 3;
   localparam int TALLY_W     = 5;
   localparam int STATUS_W    = 2;

   localparam int CQ_DEPTH    = 2;
   localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      OP_PUSH     = 3'd0,
      OP_POP      = 3'd1,
      OP_CNT_GT   = 3'd2,
      OP_CNT_EVEN = 3'd3,
      OP_REVERSE  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [WORD_W-1:0]  operand;
   } cmd_type;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
      return (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] i);
      return (i == '0) ? PTR_W'(QUEUE_DEPTH - 1) : i - PTR_W'(1);
   endfunction

endpackage

FILE: src/fqsq_if.sv
// request and response channel interfaces
interface fqsq_req_if
   import fqsq_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic signed [WORD_W-1:0]  push_value;
   logic signed [WORD_W-1:0]  threshold;

   modport source (output valid, action, push_value, threshold, input ready);
   modport sink   (input valid, action, push_value, threshold, output ready);
endinterface

interface fqsq_rsp_if
   import fqsq_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [WORD_W-1:0]  data_out;
   logic [TALLY_W-1:0]        tally;
   logic [STATUS_W-1:0]       status;
   logic                      last;

   modport source (output valid, data_out, tally, status, last, input ready);
   modport sink   (input valid, data_out, tally, status, last, output ready);
endinterface

FILE: src/fqsq_front.sv
// front end: accepts request words and classifies them into commands
module fqsq_front
   import fqsq_pkg::*;
   (
   fqsq_req_if.sink  req_chan,
   output logic      cmd_valid,
   output cmd_type   cmd,
   input  logic      cmd_ready
   );

   logic known;

   always_comb begin
      known       = 1'b1;
      cmd.op      = OP_POP;
      cmd.operand = '0;
      unique case (req_chan.action)
         OP_PUSH: begin
            cmd.op      = OP_PUSH;
            cmd.operand = req_chan.push_value;
         end
         OP_POP: begin
            cmd.op = OP_POP;
         end
         OP_CNT_GT: begin
            cmd.op      = OP_CNT_GT;
            cmd.operand = req_chan.threshold;
         end
         OP_CNT_EVEN: begin
            cmd.op = OP_CNT_EVEN;
         end
         OP_REVERSE: begin
            cmd.op = OP_REVERSE;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // unknown actions are taken and dropped
   assign cmd_valid      = req_chan.valid && known;
   assign req_chan.ready = cmd_ready;

endmodule

FILE: src/fqsq_cmd_fifo.sv
// short command queue between front and back end
module fqsq_cmd_fifo
   import fqsq_pkg::*;
   (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   input  cmd_type  wr_cmd,
   output logic     wr_ready,
   output logic     rd_valid,
   output cmd_type  rd_cmd,
   input  logic     rd_ready
   );

   cmd_type               slot_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                  do_wr, do_rd;

   function automatic logic [CQ_PTR_W-1:0] bump(input logic [CQ_PTR_W-1:0] p);
      return (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + CQ_PTR_W'(1);
   endfunction

   assign wr_ready = (cnt_ff != CQ_CNT_W'(CQ_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_rd ? bump(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CQ_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

FILE: src/fqsq_back.sv
// back end: ring buffer, scan sequencer and response register
module fqsq_back
   import fqsq_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_ready,
   fqsq_rsp_if.source  rsp_chan
   );

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_POP_OUT = 5'b00010,
      S_SCAN    = 5'b00100,
      S_CNT_OUT = 5'b01000,
      S_REV_OUT = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [PTR_W-1:0]          head_ff, head_in;
   logic [PTR_W-1:0]          tail_ff, tail_in;
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic [PTR_W-1:0]          slot_ff, slot_in;
   logic [OCC_W-1:0]          left_ff, left_in;
   logic [TALLY_W-1:0]        cnt_ff, cnt_in;
   logic                      gt_mode_ff, gt_mode_in;
   logic signed [WORD_W-1:0]  thr_ff, thr_in;

   logic signed [WORD_W-1:0]  mem [QUEUE_DEPTH];
   logic signed [WORD_W-1:0]  rd_data_ff;
   logic                      rd_en, wr_en;
   logic [PTR_W-1:0]          rd_addr;

   logic                      out_valid_ff, out_valid_in;
   logic signed [WORD_W-1:0]  out_data_ff;
   logic [TALLY_W-1:0]        out_tally_ff;
   status_type                out_status_ff;
   logic                      out_last_ff;

   logic                      out_free, out_load, hit;
   logic signed [WORD_W-1:0]  ld_data;
   logic [TALLY_W-1:0]        ld_tally;
   status_type                ld_status;
   logic                      ld_last;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign hit      = gt_mode_ff ? (rd_data_ff > thr_ff) : !rd_data_ff[0];

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      occ_in     = occ_ff;
      slot_in    = slot_ff;
      left_in    = left_ff;
      cnt_in     = cnt_ff;
      gt_mode_in = gt_mode_ff;
      thr_in     = thr_ff;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      wr_en      = 1'b0;
      cmd_ready  = 1'b0;
      out_load   = 1'b0;
      ld_data    = '0;
      ld_tally   = '0;
      ld_status  = ST_OK;
      ld_last    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               unique case (cmd.op) inside
                  OP_PUSH: begin
                     out_load = 1'b1;
                     if (occ_ff == OCC_W'(QUEUE_DEPTH)) begin
                        ld_status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = next_slot(tail_ff);
                        occ_in  = occ_ff + OCC_W'(1);
                     end
                  end
                  OP_POP: begin
                     if (occ_ff == '0) begin
                        out_load  = 1'b1;
                        ld_status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = S_POP_OUT;
                     end
                  end
                  OP_CNT_GT, OP_CNT_EVEN: begin
                     if (occ_ff == '0) begin
                        out_load = 1'b1;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = head_ff;
                        slot_in    = next_slot(head_ff);
                        left_in    = occ_ff;
                        cnt_in     = '0;
                        gt_mode_in = (cmd.op == OP_CNT_GT);
                        thr_in     = cmd.operand;
                        state_in   = S_SCAN;
                     end
                  end
                  OP_REVERSE: begin
                     if (occ_ff == '0) begin
                        out_load  = 1'b1;
                        ld_status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = prev_slot(tail_ff);
                        slot_in  = prev_slot(prev_slot(tail_ff));
                        left_in  = occ_ff;
                        state_in = S_REV_OUT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               ld_data  = rd_data_ff;
               head_in  = next_slot(head_ff);
               occ_in   = occ_ff - OCC_W'(1);
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + TALLY_W'(hit);
            if (left_ff == OCC_W'(1)) begin
               state_in = S_CNT_OUT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = slot_ff;
               slot_in = next_slot(slot_ff);
               left_in = left_ff - OCC_W'(1);
            end
         end
         S_CNT_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               ld_tally = cnt_ff;
               state_in = S_IDLE;
            end
         end
         S_REV_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               ld_data  = rd_data_ff;
               ld_last  = (left_ff == OCC_W'(1));
               if (left_ff == OCC_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = slot_ff;
                  slot_in = prev_slot(slot_ff);
                  left_in = left_ff - OCC_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // scan context and response word
   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      left_ff    <= left_in;
      cnt_ff     <= cnt_in;
      gt_mode_ff <= gt_mode_in;
      thr_ff     <= thr_in;
      if (out_load) begin
         out_data_ff   <= ld_data;
         out_tally_ff  <= ld_tally;
         out_status_ff <= ld_status;
         out_last_ff   <= ld_last;
      end
   end

   // entry store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= cmd.operand;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.data_out = out_data_ff;
   assign rsp_chan.tally    = out_tally_ff;
   assign rsp_chan.status   = out_status_ff;
   assign rsp_chan.last     = out_last_ff;

endmodule

FILE: src/fifo_queue_with_scan_queries_core.sv
// top level of the fifo queue with scan queries
//
// req_chan carries one request word: an action (push, pop, count greater
// than threshold, count even, emit reversed) with its push value and
// threshold. rsp_chan returns response words with data_out, tally, status
// and last; last marks the final word of a request. Unknown actions are
// taken and dropped without a response.
// Requests pass a two-word command queue into the back end, which serves
// one command at a time from a ring buffer of QUEUE_DEPTH words.
// Push, and an empty or full case: the response is registered in the cycle
// after the back end takes the command. Pop: one entry store read, then the
// response register. Count: the single read port of the entry store reads
// each stored entry in turn, then the tally is registered. Reverse: one word
// per cycle while the receiver is ready, newest first, after a first read.
// Reset (synchronous) empties the queue and drops queued commands and any
// pending response. A stalled receiver holds the response register; the
// back end then waits and the command queue fills before req_chan.ready drops.
module fifo_queue_with_scan_queries_core
   import fqsq_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   fqsq_req_if.sink    req_chan,
   fqsq_rsp_if.source  rsp_chan
   );

   logic     front_valid, front_ready;
   cmd_type  front_cmd;
   logic     back_valid, back_ready;
   cmd_type  back_cmd;

   fqsq_front u_front (
      .req_chan  (req_chan),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   fqsq_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_cmd   (front_cmd),
      .wr_ready (front_ready),
      .rd_valid (back_valid),
      .rd_cmd   (back_cmd),
      .rd_ready (back_ready)
   );

   fqsq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd       (back_cmd),
      .cmd_ready (back_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
